/* hw/rtl/spq_pkg.sv */
package spq_pkg;

	// Command given to each cell of the row for one update cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_cmd_t;

	// Comparison results that a cell reports against the probe tag and priority.
	typedef struct packed {
		logic ge;  // stored priority is at least the probe priority
		logic le;  // stored priority is at most the probe priority
		logic eq;  // stored tag equals the probe tag
	} cell_flags_t;

endpackage

/* hw/rtl/sorted_priority_queue.sv */
// Sorted priority queue held in a row of cells, smallest priority at cell 0.
// Input channel: in_valid/in_ready carry opcode, entry_tag and entry_priority.
// Opcodes are insert, extract minimum, decrease key and remove by tag.
// Output channel: out_valid/out_ready carry status, out_tag, out_priority and
// occupancy, exactly one result transfer for each input transfer.
// An item is compared against every cell in its transfer cycle, and the row
// shifts in the update state that follows; the result is registered when
// that update is done, and no new item is taken before then. Decrease key
// runs a remove pass and then an insert pass, with a fresh comparison between
// them.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, the following item waits in its update cycle, with
// the row unchanged, until the output register is free.
// Reset empties the queue at once; cell contents are left as they are and
// only the entry count decides which cells hold entries.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH   = 64,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           opcode,
	input  logic [TAG_BITS-1:0]                  entry_tag,
	input  logic [PRIORITY_BITS-1:0]             entry_priority,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [TAG_BITS-1:0]                  out_tag,
	output logic [PRIORITY_BITS-1:0]             out_priority,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occupancy
);

	localparam int N  = QUEUE_DEPTH;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_DECKEY  = 2'd2;
	localparam logic [1:0] OP_REMOVE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_RECMP
	} state_t;

	state_t                   state_q;
	logic [1:0]               op_q;
	logic [TAG_BITS-1:0]      tag_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     dk_second_q;
	logic                     dk_miss_q;
	logic [CW-1:0]            cnt_q;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [TAG_BITS-1:0]      out_tag_q;
	logic [PRIORITY_BITS-1:0] out_prio_q;
	logic [CW-1:0]            occupancy_q;

	logic                     in_xfer;
	logic                     cmp_en;
	logic [TAG_BITS-1:0]      cmp_tag;
	logic [PRIORITY_BITS-1:0] cmp_prio;

	logic [TAG_BITS-1:0]      cell_tag   [N];
	logic [PRIORITY_BITS-1:0] cell_prio  [N];
	cell_flags_t              cell_flags [N];
	cell_cmd_t                cell_cmd   [N];

	logic [N-1:0] v, ge, le, eq;
	logic [N-1:0] tl, nxt_oh, ge_v, m;
	logic [N-1:0] load, shl, shr;

	logic          final_step, stall, do_apply;
	logic          ins_mode, rem_mode, ext_mode;
	logic          empty, full;
	logic          append, app_sel, tail_only;
	logic [1:0]    status_d;
	logic [CW-1:0] cnt_d;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid & in_ready;

	// The probe comes from the ports at transfer time and from the held item later.
	assign cmp_en   = in_xfer | (state_q == S_RECMP);
	assign cmp_tag  = (state_q == S_IDLE) ? entry_tag : tag_q;
	assign cmp_prio = (state_q == S_IDLE) ? entry_priority : prio_q;

	// Row of cells with neighbour links; the ends take their own value.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [TAG_BITS-1:0]      lt, rt;
		logic [PRIORITY_BITS-1:0] lp, rp;

		if (i == 0) begin : g_first
			assign lt = cell_tag[i];
			assign lp = cell_prio[i];
		end else begin : g_inner_l
			assign lt = cell_tag[i-1];
			assign lp = cell_prio[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rt = cell_tag[i];
			assign rp = cell_prio[i];
		end else begin : g_inner_r
			assign rt = cell_tag[i+1];
			assign rp = cell_prio[i+1];
		end

		spq_cell #(
			.TAG_BITS      (TAG_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd[i]),
			.new_tag    (tag_q),
			.new_prio   (prio_q),
			.left_tag   (lt),
			.left_prio  (lp),
			.right_tag  (rt),
			.right_prio (rp),
			.cmp_en     (cmp_en),
			.cmp_tag    (cmp_tag),
			.cmp_prio   (cmp_prio),
			.tag        (cell_tag[i]),
			.prio       (cell_prio[i]),
			.flags      (cell_flags[i])
		);

		assign v[i]  = (CW'(i) < cnt_q);
		assign ge[i] = cell_flags[i].ge;
		assign le[i] = cell_flags[i].le;
		assign eq[i] = cell_flags[i].eq;
	end

	// Occupied cells, the tail cell and the first free cell.
	assign tl     = v & ~{1'b0, v[N-1:1]};
	assign nxt_oh = ~v & {v[N-2:0], 1'b1};
	assign ge_v   = ge & v;
	assign m      = eq & v;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(QUEUE_DEPTH));

	assign final_step = !((op_q == OP_DECKEY) && !dk_second_q);
	assign stall      = final_step & out_valid_q & ~out_ready;
	assign do_apply   = (state_q == S_APPLY) & ~stall;

	assign ins_mode = (op_q == OP_INSERT) | ((op_q == OP_DECKEY) & dk_second_q);
	assign rem_mode = (op_q == OP_REMOVE) | ((op_q == OP_DECKEY) & ~dk_second_q);
	assign ext_mode = (op_q == OP_EXTRACT);

	// Insert goes after the tail only when it is not also at or below the head.
	assign append    = |(tl & le);
	assign app_sel   = empty | (append & ~ge_v[0]);
	// Remove tests the head, then the tail, then the first match from the head.
	assign tail_only = ~m[0] & |(tl & eq);

	// Shift pattern, new count and status of the current pass.
	always_comb begin
		load     = '0;
		shl      = '0;
		shr      = '0;
		cnt_d    = cnt_q;
		status_d = ST_OK;
		if (ins_mode) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				load     = app_sel ? nxt_oh : (ge_v & ~{ge_v[N-2:0], 1'b0});
				shl      = app_sel ? '0 : {ge_v[N-2:0], 1'b0};
				cnt_d    = cnt_q + CW'(1);
				status_d = (dk_second_q & dk_miss_q) ? ST_NOTFOUND : ST_OK;
			end
		end else if (rem_mode) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else if (m == '0) begin
				status_d = ST_NOTFOUND;
			end else begin
				shr   = tail_only ? '0 : ((m | (~m + N'(1))) & v);
				cnt_d = cnt_q - CW'(1);
			end
		end else if (ext_mode) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				shr   = v;
				cnt_d = cnt_q - CW'(1);
			end
		end
	end

	// One command per cell; a cell never gets more than one kind of move.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cell_cmd[i] = CELL_HOLD;
			if (do_apply) begin
				priority if (load[i]) begin
					cell_cmd[i] = CELL_LOAD;
				end else if (shl[i]) begin
					cell_cmd[i] = CELL_FROM_LEFT;
				end else if (shr[i]) begin
					cell_cmd[i] = CELL_FROM_RIGHT;
				end else begin
					cell_cmd[i] = CELL_HOLD;
				end
			end
		end
	end

	// Held item for the update and second comparison cycles.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= opcode;
			tag_q  <= entry_tag;
			prio_q <= entry_priority;
		end
	end

	// Sequencer, entry count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dk_second_q <= 1'b0;
			dk_miss_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			out_tag_q   <= '0;
			out_prio_q  <= '0;
			occupancy_q <= '0;
		end else begin
			if (out_valid_q && out_ready && !(do_apply && final_step)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q     <= S_APPLY;
						dk_second_q <= 1'b0;
					end
				end
				S_APPLY: begin
					if (do_apply) begin
						cnt_q <= cnt_d;
						if (final_step) begin
							state_q     <= S_IDLE;
							dk_second_q <= 1'b0;
							out_valid_q <= 1'b1;
							status_q    <= status_d;
							occupancy_q <= cnt_d;
							if (ext_mode && !empty) begin
								out_tag_q  <= cell_tag[0];
								out_prio_q <= cell_prio[0];
							end else begin
								out_tag_q  <= '0;
								out_prio_q <= '0;
							end
						end else begin
							state_q     <= S_RECMP;
							dk_second_q <= 1'b1;
							dk_miss_q   <= (status_d != ST_OK);
						end
					end
				end
				S_RECMP: begin
					state_q <= S_APPLY;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_priority = out_prio_q;
	assign occupancy    = occupancy_q;

endmodule

/* hw/rtl/spq_cell.sv */
module spq_cell import spq_pkg::*; #(
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [TAG_BITS-1:0]      new_tag,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [TAG_BITS-1:0]      left_tag,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic [TAG_BITS-1:0]      right_tag,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	input  logic                     cmp_en,
	input  logic [TAG_BITS-1:0]      cmp_tag,
	input  logic [PRIORITY_BITS-1:0] cmp_prio,
	output logic [TAG_BITS-1:0]      tag,
	output logic [PRIORITY_BITS-1:0] prio,
	output cell_flags_t              flags
);

	logic [TAG_BITS-1:0]      tag_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	cell_flags_t              flags_q;

	// The entry is replaced by the new item or by a neighbour's entry, or held.
	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_LOAD: begin
				tag_q  <= new_tag;
				prio_q <= new_prio;
			end
			CELL_FROM_LEFT: begin
				tag_q  <= left_tag;
				prio_q <= left_prio;
			end
			CELL_FROM_RIGHT: begin
				tag_q  <= right_tag;
				prio_q <= right_prio;
			end
			default: begin
				tag_q  <= tag_q;
				prio_q <= prio_q;
			end
		endcase
	end

	// The comparisons are registered so that the update cycle starts from flops.
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			flags_q.ge <= (prio_q >= cmp_prio);
			flags_q.le <= (prio_q <= cmp_prio);
			flags_q.eq <= (tag_q == cmp_tag);
		end
	end

	assign tag   = tag_q;
	assign prio  = prio_q;
	assign flags = flags_q;

endmodule
